[sv/tlsa_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsa_pkg
// shared types, constants, segment tables and the control program of the
// thermistor linearize / smooth / average channel
// ----------------------------------------------------------------------------
package tlsa_pkg;

   // field widths
   localparam int TEMP_W     = 19;
   localparam int OFFS_W     = 13;
   localparam int WGT_W      = 17;
   localparam int CSR_W      = 19;
   localparam int CSR_IDX_W  = 2;
   localparam int RSP_DATA_W = 64;
   localparam int RSP_PAD_W  = RSP_DATA_W - 3 * TEMP_W;

   // fixed point
   localparam int W_ONE      = 65536;
   localparam int FRAC_SH    = 16;
   localparam int SEG_SH     = 24;
   localparam int SEG_HALF   = 1 << (SEG_SH - 1);
   localparam int BLEND_HALF = 1 << (FRAC_SH - 1);
   localparam int TEMP_MAX   = 262143;
   localparam int TEMP_MIN   = -262144;

   // segment tables
   localparam int NUM_BOUNDS = 5;
   localparam int SEG_W      = 3;
   localparam int BOUND_W    = 13;
   localparam int SLOPE_W    = 24;
   localparam int ICPT_W     = 22;

   // register reset values
   localparam int OFFSET_RST = 1675;
   localparam int WEIGHT_RST = 46226;
   localparam int UPPER_RST  = 38400;
   localparam int LOWER_RST  = -5120;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OFFSET,
      CSR_WEIGHT,
      CSR_UPPER,
      CSR_LOWER
   } csr_index_type;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_WAIT,
      OP_OFFS,
      OP_SEG,
      OP_MUL,
      OP_RND,
      OP_BLD,
      OP_BLEND,
      OP_CLAMP,
      OP_CLS,
      OP_DIV,
      OP_FIN,
      OP_EMIT
   } op_type;

   typedef enum logic [2:0] {
      C_NEXT,
      C_ALWAYS,
      C_NO_REQ,
      C_CLOSE,
      C_EMPTY,
      C_MORE,
      C_BUSY
   } cond_type;

   localparam int STEP_W = 4;
   typedef logic [STEP_W-1:0] step_type;

   localparam step_type S_EMIT  = 4'd0;
   localparam step_type S_IDLE  = 4'd1;
   localparam step_type S_OFFS  = 4'd2;
   localparam step_type S_SEG   = 4'd3;
   localparam step_type S_MUL1  = 4'd4;
   localparam step_type S_RND   = 4'd5;
   localparam step_type S_BLD   = 4'd6;
   localparam step_type S_MUL2  = 4'd7;
   localparam step_type S_BLEND = 4'd8;
   localparam step_type S_CLAMP = 4'd9;
   localparam step_type S_CLS   = 4'd10;
   localparam step_type S_DIV   = 4'd11;
   localparam step_type S_FIN   = 4'd12;

   typedef struct packed {
      op_type   op;
      cond_type cond;
      step_type target;
   } ctrl_type;

   typedef struct packed {
      logic req_valid;
      logic is_close;
      logic win_empty;
      logic div_more;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic is_close;
      logic win_empty;
      logic div_more;
   } dp_stat_type;

   typedef struct packed {
      logic signed [OFFS_W-1:0] offset;
      logic [WGT_W-1:0]         weight;
      logic signed [TEMP_W-1:0] upper;
      logic signed [TEMP_W-1:0] lower;
   } cfg_type;

   typedef struct packed {
      logic signed [TEMP_W-1:0] linear;
      logic signed [TEMP_W-1:0] filtered;
      logic signed [TEMP_W-1:0] average;
      logic                     avg_valid;
   } result_type;

   function automatic logic signed [BOUND_W-1:0] seg_bound(input logic [SEG_W-1:0] idx);
      logic signed [BOUND_W-1:0] b;
      case (idx)
         3'd0:    b = 13'sd414;
         3'd1:    b = 13'sd669;
         3'd2:    b = 13'sd1100;
         3'd3:    b = 13'sd1803;
         default: b = 13'sd2820;
      endcase
      return b;
   endfunction

   // slopes in Q24
   function automatic logic signed [SLOPE_W-1:0] seg_slope(input logic [SEG_W-1:0] idx);
      logic signed [SLOPE_W-1:0] s;
      case (idx)
         3'd0:    s = -24'sd2105876;
         3'd1:    s = -24'sd1246547;
         3'd2:    s = -24'sd741721;
         3'd3:    s = -24'sd454495;
         3'd4:    s = -24'sd319103;
         default: s = -24'sd278334;
      endcase
      return s;
   endfunction

   // intercepts in Q8
   function automatic logic signed [ICPT_W-1:0] seg_icpt(input logic [SEG_W-1:0] idx);
      logic signed [ICPT_W-1:0] c;
      case (idx)
         3'd0:    c = 22'sd319797;
         3'd1:    c = 22'sd463777;
         3'd2:    c = 22'sd657251;
         3'd3:    c = 22'sd886110;
         3'd4:    c = 22'sd1058157;
         default: c = 22'sd1105762;
      endcase
      return c;
   endfunction

   // control program: jump to target when the condition holds, else next step
   function automatic ctrl_type ucode(input step_type s);
      ctrl_type u;
      case (s)
         S_EMIT:  u = '{OP_EMIT,  C_BUSY,   S_EMIT};
         S_IDLE:  u = '{OP_WAIT,  C_NO_REQ, S_IDLE};
         S_OFFS:  u = '{OP_OFFS,  C_CLOSE,  S_CLS};
         S_SEG:   u = '{OP_SEG,   C_NEXT,   S_IDLE};
         S_MUL1:  u = '{OP_MUL,   C_NEXT,   S_IDLE};
         S_RND:   u = '{OP_RND,   C_NEXT,   S_IDLE};
         S_BLD:   u = '{OP_BLD,   C_NEXT,   S_IDLE};
         S_MUL2:  u = '{OP_MUL,   C_NEXT,   S_IDLE};
         S_BLEND: u = '{OP_BLEND, C_NEXT,   S_IDLE};
         S_CLAMP: u = '{OP_CLAMP, C_ALWAYS, S_EMIT};
         S_CLS:   u = '{OP_CLS,   C_EMPTY,  S_EMIT};
         S_DIV:   u = '{OP_DIV,   C_MORE,   S_DIV};
         S_FIN:   u = '{OP_FIN,   C_ALWAYS, S_EMIT};
         default: u = '{OP_NOP,   C_ALWAYS, S_IDLE};
      endcase
      return u;
   endfunction

endpackage
`default_nettype wire

[sv/thermistor_linearize_smooth_average.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// thermistor_linearize_smooth_average
// one heat-sink temperature channel: piecewise linearization of an adc code,
// smoothing with clamp, and window averaging closed on demand
// ----------------------------------------------------------------------------
// sequence: a sample request runs offset, segment, multiply, round, blend
//   setup, multiply, blend and clamp steps, a close request runs offset,
//   close, divide and finish steps, the divider retiring one quotient bit
//   per control step; both end in the emit step, which holds while the
//   response is not taken; the control program runs one request at a time
// reset: synchronous, clears the window, the previous temperature and the
//   response valid, and loads the register reset values; no clearing pass
// ----------------------------------------------------------------------------
module thermistor_linearize_smooth_average #(
   parameter int ADC_BITS   = 12,
   parameter int MAX_WINDOW = 1024
) (
   input  logic                               clock,
   input  logic                               reset,
   // request channel
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // tdata: raw_sample, zero pad to whole bytes
   input  logic [((ADC_BITS + 7) / 8) * 8-1:0] req_tdata,
   // tuser: action (0 sample, 1 close window)
   input  logic                               req_tuser,
   // response channel
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // tdata: linear_temp, filtered_temp, window_average, zero pad
   output logic [tlsa_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // tuser: average_valid
   output logic                               rsp_tuser,
   // configuration write port
   input  logic                               csr_we,
   input  logic [tlsa_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tlsa_pkg::CSR_W-1:0]         csr_wdata
);
   import tlsa_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   ctrl_type    ctrl;
   status_type  status;
   dp_stat_type dp_stat;
   result_type  result;
   result_type  rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic        req_accept;
   logic        out_busy;
   logic        out_load;

   // request is taken only in the wait step of the program
   assign req_tready = (ctrl.op == OP_WAIT);
   assign req_accept = req_tvalid && req_tready;

   // response register frees the datapath while a result waits
   assign out_busy = rsp_valid_ff && !rsp_tready;
   assign out_load = (ctrl.op == OP_EMIT) && !out_busy;

   always_comb begin
      status.req_valid = req_tvalid;
      status.is_close  = dp_stat.is_close;
      status.win_empty = dp_stat.win_empty;
      status.div_more  = dp_stat.div_more;
      status.out_busy  = out_busy;
   end

   // configuration registers
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OFFSET: cfg_in.offset = csr_wdata[OFFS_W-1:0];
            CSR_WEIGHT: cfg_in.weight = csr_wdata[WGT_W-1:0];
            CSR_UPPER:  cfg_in.upper  = csr_wdata[TEMP_W-1:0];
            CSR_LOWER:  cfg_in.lower  = csr_wdata[TEMP_W-1:0];
            default:    cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.offset <= OFFS_W'(OFFSET_RST);
         cfg_ff.weight <= WGT_W'(WEIGHT_RST);
         cfg_ff.upper  <= TEMP_W'(UPPER_RST);
         cfg_ff.lower  <= TEMP_W'(LOWER_RST);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // response register
   always_comb begin
      rsp_in       = out_load ? result : rsp_ff;
      rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && !rsp_tready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{RSP_PAD_W{1'b0}}, rsp_ff.average, rsp_ff.filtered, rsp_ff.linear};
   assign rsp_tuser  = rsp_ff.avg_valid;

   // control program sequencer
   tlsa_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .status (status),
      .ctrl   (ctrl)
   );

   // arithmetic datapath
   tlsa_dp #(
      .ADC_BITS   (ADC_BITS),
      .MAX_WINDOW (MAX_WINDOW)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .op         (ctrl.op),
      .req_accept (req_accept),
      .req_action (req_tuser),
      .req_raw    (req_tdata[ADC_BITS-1:0]),
      .cfg        (cfg_ff),
      .stat       (dp_stat),
      .result     (result)
   );

endmodule
`default_nettype wire

[sv/tlsa_seq.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsa_seq
// step counter and control program lookup with conditional jumps
// ----------------------------------------------------------------------------
module tlsa_seq (
   input  logic                 clock,
   input  logic                 reset,
   input  tlsa_pkg::status_type status,
   output tlsa_pkg::ctrl_type   ctrl
);
   import tlsa_pkg::*;

   step_type pc_ff;
   step_type pc_in;
   logic     jump;

   always_comb begin
      ctrl = ucode(pc_ff);
   end

   always_comb begin
      case (ctrl.cond)
         C_NEXT:   jump = 1'b0;
         C_ALWAYS: jump = 1'b1;
         C_NO_REQ: jump = !status.req_valid;
         C_CLOSE:  jump = status.is_close;
         C_EMPTY:  jump = status.win_empty;
         C_MORE:   jump = status.div_more;
         C_BUSY:   jump = status.out_busy;
         default:  jump = 1'b0;
      endcase
      pc_in = jump ? ctrl.target : pc_ff + STEP_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= S_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule
`default_nettype wire

[sv/tlsa_dp.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tlsa_dp
// datapath: offset, segment select, shared multiplier, rounding, blend,
// clamp, window accumulator and a one bit per step restoring divider
// ----------------------------------------------------------------------------
module tlsa_dp #(
   parameter int ADC_BITS   = 12,
   parameter int MAX_WINDOW = 1024
) (
   input  logic                  clock,
   input  logic                  reset,
   input  tlsa_pkg::op_type      op,
   input  logic                  req_accept,
   input  logic                  req_action,
   input  logic [ADC_BITS-1:0]   req_raw,
   input  tlsa_pkg::cfg_type     cfg,
   output tlsa_pkg::dp_stat_type stat,
   output tlsa_pkg::result_type  result
);
   import tlsa_pkg::*;

   localparam int X_W    = ((ADC_BITS > OFFS_W) ? ADC_BITS : OFFS_W) + 2;
   localparam int MA_W   = X_W + 9;
   localparam int P_W    = MA_W + SLOPE_W;
   localparam int CNT_W  = $clog2(MAX_WINDOW + 1);
   localparam int SUM_W  = TEMP_W + CNT_W;
   localparam int ITER_W = $clog2(SUM_W);

   logic                     action_ff, action_in;
   logic [ADC_BITS-1:0]      raw_ff, raw_in;
   logic signed [X_W-1:0]    x_ff, x_in;
   logic signed [MA_W-1:0]   opa_ff, opa_in;
   logic signed [SLOPE_W-1:0] opb_ff, opb_in;
   logic signed [P_W-1:0]    prod_ff, prod_in;
   logic signed [TEMP_W-1:0] temp_ff, temp_in;
   logic signed [TEMP_W-1:0] blend_ff, blend_in;
   logic signed [TEMP_W-1:0] filt_ff, filt_in;
   logic signed [TEMP_W-1:0] prev_ff, prev_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [SUM_W-1:0]         quo_ff, quo_in;
   logic [CNT_W-1:0]         rem_ff, rem_in;
   logic [CNT_W-1:0]         div_ff, div_in;
   logic [ITER_W-1:0]        iter_ff, iter_in;
   logic                     neg_ff, neg_in;
   logic signed [TEMP_W-1:0] avg_ff, avg_in;
   logic                     avgv_ff, avgv_in;

   logic [SEG_W-1:0]         seg_sel;
   logic signed [P_W:0]      rnd_sum;
   logic signed [P_W:0]      rnd_shift;
   logic signed [P_W:0]      blend_sum;
   logic [WGT_W-1:0]         w_clamp;
   logic [CNT_W:0]           trial;
   logic [CNT_W:0]           trial_diff;
   logic                     trial_ge;

   // segment pick: bounds ascend, so the last bound passed wins
   always_comb begin
      seg_sel = '0;
      for (int i = 0; i < NUM_BOUNDS; i++) begin
         if (x_ff >= X_W'(seg_bound(SEG_W'(i)))) begin
            seg_sel = SEG_W'(i + 1);
         end
      end
   end

   always_comb begin
      rnd_sum   = (P_W + 1)'(prod_ff) + (P_W + 1)'(SEG_HALF);
      rnd_shift = rnd_sum >>> SEG_SH;
      blend_sum = ((P_W + 1)'(temp_ff) <<< FRAC_SH) + (P_W + 1)'(prod_ff)
                  + (P_W + 1)'(BLEND_HALF);
      w_clamp   = (cfg.weight > WGT_W'(W_ONE)) ? WGT_W'(W_ONE) : cfg.weight;
      trial     = {rem_ff, quo_ff[SUM_W-1]};
      trial_ge  = trial >= {1'b0, div_ff};
      trial_diff = trial - {1'b0, div_ff};
   end

   always_comb begin
      action_in = action_ff;
      raw_in    = raw_ff;
      x_in      = x_ff;
      opa_in    = opa_ff;
      opb_in    = opb_ff;
      prod_in   = prod_ff;
      temp_in   = temp_ff;
      blend_in  = blend_ff;
      filt_in   = filt_ff;
      prev_in   = prev_ff;
      sum_in    = sum_ff;
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      div_in    = div_ff;
      iter_in   = iter_ff;
      neg_in    = neg_ff;
      avg_in    = avg_ff;
      avgv_in   = avgv_ff;
      case (op)
         OP_WAIT: begin
            if (req_accept) begin
               action_in = req_action;
               raw_in    = req_raw;
            end
         end
         OP_OFFS: begin
            x_in = X_W'($signed({1'b0, raw_ff})) - X_W'($signed(cfg.offset));
         end
         OP_SEG: begin
            opa_in = (MA_W'(x_ff) <<< 8) - MA_W'(seg_icpt(seg_sel));
            opb_in = seg_slope(seg_sel);
         end
         OP_MUL: begin
            prod_in = opa_ff * opb_ff;
         end
         OP_RND: begin
            if (rnd_shift > (P_W + 1)'(TEMP_MAX)) begin
               temp_in = TEMP_W'(TEMP_MAX);
            end else if (rnd_shift < (P_W + 1)'(TEMP_MIN)) begin
               temp_in = TEMP_W'(TEMP_MIN);
            end else begin
               temp_in = rnd_shift[TEMP_W-1:0];
            end
         end
         OP_BLD: begin
            // temp + w * (prev - temp) equals the weighted blend
            opa_in = MA_W'(prev_ff) - MA_W'(temp_ff);
            opb_in = SLOPE_W'($signed({1'b0, w_clamp}));
         end
         OP_BLEND: begin
            blend_in = blend_sum[FRAC_SH +: TEMP_W];
         end
         OP_CLAMP: begin
            if (blend_ff > cfg.upper) begin
               filt_in = cfg.upper;
            end else if (blend_ff < cfg.lower) begin
               filt_in = cfg.lower;
            end else begin
               filt_in = blend_ff;
            end
            prev_in = temp_ff;
            if (count_ff < CNT_W'(MAX_WINDOW)) begin
               sum_in   = sum_ff + SUM_W'(temp_ff);
               count_in = count_ff + CNT_W'(1);
            end
            avg_in  = '0;
            avgv_in = 1'b0;
         end
         OP_CLS: begin
            avg_in   = '0;
            avgv_in  = 1'b0;
            neg_in   = sum_ff[SUM_W-1];
            quo_in   = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
            rem_in   = '0;
            div_in   = count_ff;
            iter_in  = ITER_W'(SUM_W - 1);
            sum_in   = '0;
            count_in = '0;
         end
         OP_DIV: begin
            rem_in  = trial_ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
            quo_in  = {quo_ff[SUM_W-2:0], trial_ge};
            iter_in = iter_ff - ITER_W'(1);
         end
         OP_FIN: begin
            avg_in  = neg_ff ? -$signed(quo_ff[TEMP_W-1:0]) : $signed(quo_ff[TEMP_W-1:0]);
            avgv_in = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // architectural state
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff  <= '0;
         sum_ff   <= '0;
         count_ff <= '0;
      end else begin
         prev_ff  <= prev_in;
         sum_ff   <= sum_in;
         count_ff <= count_in;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      action_ff <= action_in;
      raw_ff    <= raw_in;
      x_ff      <= x_in;
      opa_ff    <= opa_in;
      opb_ff    <= opb_in;
      prod_ff   <= prod_in;
      temp_ff   <= temp_in;
      blend_ff  <= blend_in;
      filt_ff   <= filt_in;
      quo_ff    <= quo_in;
      rem_ff    <= rem_in;
      div_ff    <= div_in;
      iter_ff   <= iter_in;
      neg_ff    <= neg_in;
      avg_ff    <= avg_in;
      avgv_ff   <= avgv_in;
   end

   always_comb begin
      stat.is_close    = action_ff;
      stat.win_empty   = (count_ff == '0);
      stat.div_more    = (iter_ff != '0);
      result.linear    = action_ff ? '0 : temp_ff;
      result.filtered  = action_ff ? '0 : filt_ff;
      result.average   = avg_ff;
      result.avg_valid = avgv_ff;
   end

endmodule
`default_nettype wire
